@@ rtl/core/tlrg_pkg.sv @@
package tlrg_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_PIXEL_OFFSET_X = 3'd0;
	localparam logic [2:0] CFG_PIXEL_OFFSET_Y = 3'd1;
	localparam logic [2:0] CFG_PIXEL_SIZE     = 3'd2;
	localparam logic [2:0] CFG_FOCUS_DEPTH    = 3'd3;
	localparam logic [2:0] CFG_LENS_RADIUS    = 3'd4;

	localparam logic [31:0] FOCUS_DEPTH_RST = 32'd65536;

	// 1.0 in q.30 and pi/4 in q.30, rounded
	localparam logic [30:0] ONE        = 31'h4000_0000;
	localparam logic [31:0] NEG_ONE    = 32'hC000_0000;
	localparam logic [29:0] PI_QUARTER = 30'd843314857;

	// taylor divisors of the horner steps and their reciprocals (floor of 2^32/d)
	localparam logic [5:0] COS_DIV [4] = '{6'd56, 6'd30, 6'd12, 6'd2};
	localparam logic [5:0] SIN_DIV [3] = '{6'd42, 6'd20, 6'd6};
	localparam logic [31:0] COS_REC [4] = '{
		32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 30),
		32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)};
	localparam logic [31:0] SIN_REC [3] = '{
		32'((64'd1 << 32) / 42), 32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)};

	// everything a word carries down the pipeline
	typedef struct packed {
		logic signed [20:0] fdx;
		logic signed [20:0] fdy;
		logic [43:0]        fxm;
		logic [43:0]        fym;
		logic               fxn;
		logic               fyn;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic               zero;
		logic               first;
		logic               tneg;
		logic               rneg;
		logic [16:0]        rmag;
		logic [17:0]        drem;
		logic [16:0]        tq;
		logic [29:0]        theta;
		logic [29:0]        x2;
		logic [30:0]        sp;
		logic [30:0]        cq;
		logic [29:0]        sprod;
		logic [29:0]        cprod;
		logic [29:0]        squo;
		logic [29:0]        cquo;
		logic [30:0]        rcm;
		logic [30:0]        rsm;
		logic [32:0]        oxm;
		logic [32:0]        oym;
		logic               oxn;
		logic               oyn;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic [2:0][39:0]   vm;
		logic [2:0]         vn;
		logic [39:0]        mx;
		logic               vz;
		logic [4:0]         hlen;
		logic [4:0]         llen;
		logic [2:0][29:0]   nm;
		logic [2:0][59:0]   sq;
		logic [61:0]        srem;
		logic [30:0]        root;
		logic [2:0][31:0]   qrem;
		logic [2:0][30:0]   dq;
		logic [2:0][31:0]   dir;
	} item_t;

endpackage

@@ rtl/core/thin_lens_ray_generation_unit.sv @@
// channel  signals                                      direction
// cfg      cfg_we, cfg_index, cfg_data                  write only
// in       in_valid/in_ready, pixel_x/y, lens_u/v       sample words in
// out      out_valid/out_ready, origin_x/y, dir_x/y/z   ray words out
//
// one word per cycle while the skid slot is empty, through the 54-stage
// pipeline whose longest parts are the 31-step square root (two steps a stage)
// and the three 31-step direction dividers (four steps a stage)
// reset clears the valid bits, the skid slot and the config registers but focus depth
// a stalled result goes to a skid slot; the pipeline halts while it is full
module thin_lens_ray_generation_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [19:0]        pixel_x,
	input  logic [19:0]        pixel_y,
	input  logic [15:0]        lens_u,
	input  logic [15:0]        lens_v,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] origin_x,
	output logic signed [31:0] origin_y,
	output logic signed [31:0] dir_x,
	output logic signed [31:0] dir_y,
	output logic signed [31:0] dir_z
);

	localparam int NST        = 54;
	localparam int ST_DIV0    = 2;
	localparam int DIV_STG    = 5;
	localparam int DIV_PER    = 4;
	localparam int DIV_STEPS  = 17;
	localparam int ST_THETA   = 7;
	localparam int ST_X2      = 8;
	localparam int ST_HORN    = 9;
	localparam int ST_ROT     = 21;
	localparam int ST_ORG     = 22;
	localparam int ST_OSAT    = 23;
	localparam int ST_VEC     = 24;
	localparam int ST_MAX     = 25;
	localparam int ST_LEN     = 26;
	localparam int ST_NORM    = 27;
	localparam int ST_SQ      = 28;
	localparam int ST_SUM     = 29;
	localparam int ST_ROOT0   = 30;
	localparam int ROOT_STG   = 16;
	localparam int ST_QDIV0   = 46;
	localparam int QDIV_STG   = 8;
	localparam int QDIV_PER   = 4;
	localparam int QDIV_STEPS = 31;
	localparam int ST_OUT     = 54;

	logic [19:0] pixel_offset_x_q;
	logic [19:0] pixel_offset_y_q;
	logic [31:0] pixel_size_q;
	logic [31:0] focus_depth_q;
	logic [31:0] lens_radius_q;

	tlrg_pkg::item_t item_s [NST:1];
	tlrg_pkg::item_t nxt [NST:1];
	logic [NST:1]    vld_s;
	tlrg_pkg::item_t sk_q;
	logic            sk_vld_q;
	tlrg_pkg::item_t out_word;
	logic            en;

	function automatic logic signed [31:0] sat32(input logic [43:0] m, input logic n);
		logic signed [31:0] r;
		if (!n) begin
			r = (m > 44'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
		end else begin
			r = (m > 44'h0_8000_0000) ? 32'sh8000_0000 : $signed(-m[31:0]);
		end
		return r;
	endfunction

	function automatic logic [4:0] bitlen20(input logic [19:0] v);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 20; i++) begin
			if (v[i]) n = 5'(i + 1);
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_offset_x_q <= '0;
			pixel_offset_y_q <= '0;
			pixel_size_q     <= '0;
			focus_depth_q    <= tlrg_pkg::FOCUS_DEPTH_RST;
			lens_radius_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tlrg_pkg::CFG_PIXEL_OFFSET_X: pixel_offset_x_q <= cfg_data[19:0];
				tlrg_pkg::CFG_PIXEL_OFFSET_Y: pixel_offset_y_q <= cfg_data[19:0];
				tlrg_pkg::CFG_PIXEL_SIZE:     pixel_size_q     <= cfg_data;
				tlrg_pkg::CFG_FOCUS_DEPTH:    focus_depth_q    <= cfg_data;
				tlrg_pkg::CFG_LENS_RADIUS:    lens_radius_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		tlrg_pkg::item_t   w;
		logic signed [17:0] a, b;
		logic [16:0]        am, bm;
		logic [19:0]        fmag;
		logic [51:0]        fprod;
		logic [46:0]        tprod;
		logic [59:0]        p60;
		logic [61:0]        r62;
		logic [31:0]        rem32;
		logic [30:0]        qc;
		logic [47:0]        p48;
		logic [62:0]        p63;
		logic [30:0]        dxm, dym;
		logic               dxn, dyn;
		logic signed [32:0] d33;
		logic [5:0]         bl;
		logic [61:0]        trial;
		int                 n, kk;

		// stage 1: centre the lens sample, pick the major axis, film offsets
		w = '0;
		a = $signed({1'b0, lens_u, 1'b0}) - 18'sd65536;
		b = $signed({1'b0, lens_v, 1'b0}) - 18'sd65536;
		am = a[17] ? 17'(-a) : 17'(a);
		bm = b[17] ? 17'(-b) : 17'(b);
		w.first = am > bm;
		w.rmag  = w.first ? am : bm;
		w.drem  = 18'(w.first ? bm : am);
		w.rneg  = w.first ? a[17] : b[17];
		w.tneg  = a[17] ^ b[17];
		w.zero  = (a == 18'sd0) && (b == 18'sd0);
		w.tq    = '0;
		w.fdx   = $signed({1'b0, pixel_x}) - $signed({1'b0, pixel_offset_x_q});
		w.fdy   = $signed({1'b0, pixel_offset_y_q}) - $signed({1'b0, pixel_y});
		nxt[1] = w;

		for (int st = 2; st <= NST; st++) begin
			w = item_s[st-1];

			if (st == ST_DIV0) begin
				fmag = w.fdx[20] ? 20'(-w.fdx) : 20'(w.fdx);
				fprod = 52'(fmag) * 52'(pixel_size_q);
				w.fxm = fprod[51:8];
				w.fxn = w.fdx[20];
				fmag = w.fdy[20] ? 20'(-w.fdy) : 20'(w.fdy);
				fprod = 52'(fmag) * 52'(pixel_size_q);
				w.fym = fprod[51:8];
				w.fyn = w.fdy[20];
			end

			// t = minor / major as a q1.16 quotient, restoring steps
			if (st >= ST_DIV0 && st < ST_DIV0 + DIV_STG) begin
				for (int j = 0; j < DIV_PER; j++) begin
					n = (st - ST_DIV0) * DIV_PER + j;
					if (n < DIV_STEPS) begin
						if (w.drem >= 18'(w.rmag)) begin
							w.drem = w.drem - 18'(w.rmag);
							w.tq = {w.tq[15:0], 1'b1};
						end else begin
							w.tq = {w.tq[15:0], 1'b0};
						end
						w.drem = {w.drem[16:0], 1'b0};
					end
				end
			end

			if (st == ST_THETA) begin
				tprod = 47'(w.tq) * 47'(tlrg_pkg::PI_QUARTER);
				w.theta = tprod[45:16];
				w.fx = sat32(w.fxm, w.fxn);
				w.fy = sat32(w.fym, w.fyn);
			end

			if (st == ST_X2) begin
				p60 = 60'(w.theta) * 60'(w.theta);
				w.x2 = p60[59:30];
				w.sp = tlrg_pkg::ONE;
				w.cq = tlrg_pkg::ONE;
			end

			// horner steps: multiply, reciprocal multiply, correct and subtract
			for (int k = 0; k < 4; k++) begin
				if (st == ST_HORN + 3 * k) begin
					p60 = 60'(w.x2) * 60'(w.cq);
					w.cprod = p60[59:30];
				end
				if (st == ST_HORN + 3 * k + 1) begin
					r62 = 62'(w.cprod) * 62'(tlrg_pkg::COS_REC[k]);
					w.cquo = r62[61:32];
				end
				if (st == ST_HORN + 3 * k + 2) begin
					rem32 = 32'(w.cprod) - 32'(w.cquo) * 32'(tlrg_pkg::COS_DIV[k]);
					qc = 31'(w.cquo) +
						((rem32 >= 32'(tlrg_pkg::COS_DIV[k])) ? 31'd1 : 31'd0);
					w.cq = tlrg_pkg::ONE - qc;
				end
			end
			for (int k = 0; k < 3; k++) begin
				if (st == ST_HORN + 3 * k) begin
					p60 = 60'(w.x2) * 60'(w.sp);
					w.sprod = p60[59:30];
				end
				if (st == ST_HORN + 3 * k + 1) begin
					r62 = 62'(w.sprod) * 62'(tlrg_pkg::SIN_REC[k]);
					w.squo = r62[61:32];
				end
				if (st == ST_HORN + 3 * k + 2) begin
					rem32 = 32'(w.sprod) - 32'(w.squo) * 32'(tlrg_pkg::SIN_DIV[k]);
					qc = 31'(w.squo) +
						((rem32 >= 32'(tlrg_pkg::SIN_DIV[k])) ? 31'd1 : 31'd0);
					w.sp = tlrg_pkg::ONE - qc;
				end
			end
			// last sin product by theta while cos does its last step
			if (st == ST_HORN + 9) begin
				p60 = 60'(w.theta) * 60'(w.sp);
				w.sp = {1'b0, p60[59:30]};
			end

			if (st == ST_ROT) begin
				p48 = 48'(w.rmag) * 48'(w.cq);
				w.rcm = p48[46:16];
				p48 = 48'(w.rmag) * 48'(w.sp);
				w.rsm = p48[46:16];
			end

			if (st == ST_ORG) begin
				dxm = w.first ? w.rcm : w.rsm;
				dym = w.first ? w.rsm : w.rcm;
				dxn = w.first ? w.rneg : (w.rneg ^ w.tneg);
				dyn = w.first ? (w.rneg ^ w.tneg) : w.rneg;
				if (w.zero) begin
					dxm = '0;
					dym = '0;
				end
				p63 = 63'(dxm) * 63'(lens_radius_q);
				w.oxm = p63[62:30];
				p63 = 63'(dym) * 63'(lens_radius_q);
				w.oym = p63[62:30];
				w.oxn = dxn;
				w.oyn = dyn;
			end

			if (st == ST_OSAT) begin
				w.ox = sat32(44'(w.oxm), w.oxn);
				w.oy = sat32(44'(w.oym), w.oyn);
			end

			if (st == ST_VEC) begin
				d33 = $signed({w.fx[31], w.fx}) - $signed({w.ox[31], w.ox});
				w.vn[0] = d33[32];
				w.vm[0] = 40'(d33[32] ? 33'(-d33) : 33'(d33));
				d33 = $signed({w.fy[31], w.fy}) - $signed({w.oy[31], w.oy});
				w.vn[1] = d33[32];
				w.vm[1] = 40'(d33[32] ? 33'(-d33) : 33'(d33));
				w.vn[2] = 1'b1;
				w.vm[2] = {focus_depth_q, 8'd0};
			end

			if (st == ST_MAX) begin
				w.mx = w.vm[0];
				if (w.vm[1] > w.mx) w.mx = w.vm[1];
				if (w.vm[2] > w.mx) w.mx = w.vm[2];
				w.vz = (w.mx == 40'd0);
			end

			if (st == ST_LEN) begin
				w.hlen = bitlen20(w.mx[39:20]);
				w.llen = bitlen20(w.mx[19:0]);
			end

			// bring the largest magnitude into [2^29, 2^30)
			if (st == ST_NORM) begin
				bl = (w.hlen != 5'd0) ? 6'(w.hlen) + 6'd20 : 6'(w.llen);
				for (int i = 0; i < 3; i++) begin
					if (bl > 6'd30) begin
						w.nm[i] = 30'(w.vm[i] >> (bl - 6'd30));
					end else begin
						w.nm[i] = 30'(w.vm[i] << (6'd30 - bl));
					end
				end
			end

			if (st == ST_SQ) begin
				for (int i = 0; i < 3; i++) begin
					w.sq[i] = 60'(w.nm[i]) * 60'(w.nm[i]);
				end
			end

			if (st == ST_SUM) begin
				w.srem = 62'(w.sq[0]) + 62'(w.sq[1]) + 62'(w.sq[2]);
				w.root = '0;
			end

			// square root, one result bit per step, msb first
			if (st >= ST_ROOT0 && st < ST_ROOT0 + ROOT_STG) begin
				for (int j = 0; j < 2; j++) begin
					kk = 30 - 2 * (st - ST_ROOT0) - j;
					if (kk >= 0) begin
						trial = (62'(w.root) << (kk + 1)) + (62'd1 << (2 * kk));
						if (w.srem >= trial) begin
							w.srem = w.srem - trial;
							w.root[kk] = 1'b1;
						end
					end
				end
			end

			// direction = magnitude * 2^30 / length, three lanes
			if (st == ST_QDIV0) begin
				for (int i = 0; i < 3; i++) begin
					w.qrem[i] = 32'(w.nm[i]);
					w.dq[i] = '0;
				end
			end
			if (st >= ST_QDIV0 && st < ST_QDIV0 + QDIV_STG) begin
				for (int j = 0; j < QDIV_PER; j++) begin
					n = (st - ST_QDIV0) * QDIV_PER + j;
					if (n < QDIV_STEPS) begin
						for (int i = 0; i < 3; i++) begin
							if (w.qrem[i] >= 32'(w.root)) begin
								w.qrem[i] = w.qrem[i] - 32'(w.root);
								w.dq[i] = {w.dq[i][29:0], 1'b1};
							end else begin
								w.dq[i] = {w.dq[i][29:0], 1'b0};
							end
							w.qrem[i] = {w.qrem[i][30:0], 1'b0};
						end
					end
				end
			end

			if (st == ST_OUT) begin
				for (int i = 0; i < 3; i++) begin
					w.dir[i] = w.vn[i] ? 32'(-{1'b0, w.dq[i]}) : {1'b0, w.dq[i]};
				end
				// focal point on the lens point: straight down -z
				if (w.vz) begin
					w.dir[0] = '0;
					w.dir[1] = '0;
					w.dir[2] = tlrg_pkg::NEG_ONE;
				end
			end

			nxt[st] = w;
		end
	end

	assign en = !sk_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= NST; k++) begin
				item_s[k] <= nxt[k];
			end
		end
	end

	// skid slot takes the last stage word when the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sk_vld_q <= 1'b0;
		end else if (sk_vld_q) begin
			if (out_ready) sk_vld_q <= 1'b0;
		end else if (vld_s[NST] && !out_ready) begin
			sk_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!sk_vld_q && vld_s[NST] && !out_ready) begin
			sk_q <= item_s[NST];
		end
	end

	assign out_word  = sk_vld_q ? sk_q : item_s[NST];
	assign out_valid = sk_vld_q || vld_s[NST];
	assign origin_x  = out_word.ox;
	assign origin_y  = out_word.oy;
	assign dir_x     = $signed(out_word.dir[0]);
	assign dir_y     = $signed(out_word.dir[1]);
	assign dir_z     = $signed(out_word.dir[2]);

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_vld_q) |-> $past(vld_s[NST] && !out_ready))
		else $error("skid slot filled without a stalled word");

	a_dir_z_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dir_z <= 32'sd0)
		else $error("ray direction points away from the focal plane");

	a_dir_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dir_x >= -32'sd1073741824 && dir_x <= 32'sd1073741824 &&
			dir_y >= -32'sd1073741824 && dir_y <= 32'sd1073741824)
		else $error("direction component beyond unit length");

endmodule

@@ tb/testbench.sv @@
module testbench;

	typedef struct {
		logic [19:0] px;
		logic [19:0] py;
		logic [15:0] u;
		logic [15:0] v;
	} sample_t;

	typedef struct {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
	} ray_t;

	localparam longint unsigned Q30 = 64'd1 << 30;
	localparam int STALL_LIMIT = 4000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [19:0] pixel_x = '0, pixel_y = '0;
	logic [15:0] lens_u = '0, lens_v = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] origin_x, origin_y, dir_x, dir_y, dir_z;

	// predictor copy of the registers
	longint off_x, off_y, pix_size, focus, radius;

	sample_t pending_samples[$];
	ray_t expected_rays[$];
	int errors = 0;
	int rays_seen = 0;
	int phases_run = 0;
	bit quiet = 0;
	bit taken = 0;
	int in_gap = 0, out_gap = 0;
	int stall_cycles = 0;

	thin_lens_ray_generation_unit dut (.*);

	initial forever #6 clk = ~clk;

	function automatic longint unsigned mag(longint a);
		return longint'(a < 0 ? -a : a);
	endfunction

	function automatic longint scale_trunc(longint a, longint unsigned b, int sh);
		longint unsigned m;
		m = (mag(a) * b) >> sh;
		return a < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp32(longint a);
		if (a > 64'sd2147483647) return 64'sd2147483647;
		if (a < -64'sd2147483648) return -64'sd2147483648;
		return a;
	endfunction

	function automatic longint unsigned q30mul(longint unsigned a, longint unsigned b);
		return (a * b) >> 30;
	endfunction

	function automatic longint unsigned taylor_sin(longint unsigned x);
		longint unsigned x2, p;
		x2 = q30mul(x, x);
		p = Q30 - x2 / 42;
		p = Q30 - q30mul(x2, p) / 20;
		p = Q30 - q30mul(x2, p) / 6;
		return q30mul(x, p);
	endfunction

	function automatic longint unsigned taylor_cos(longint unsigned x);
		longint unsigned x2, q;
		x2 = q30mul(x, x);
		q = Q30 - x2 / 56;
		q = Q30 - q30mul(x2, q) / 30;
		q = Q30 - q30mul(x2, q) / 12;
		q = Q30 - q30mul(x2, q) / 2;
		return q;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else
				res >>= 1;
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic ray_t trace_ray(sample_t s);
		ray_t r;
		longint a, b, dkx, dky, rr, t, c, sn, rc, rs, ox, oy, fx, fy;
		longint vv[3], dd[3];
		longint unsigned m[3], mx, theta, sum, len;
		bit first;
		int sh;
		a = 2 * longint'(s.u) - 65536;
		b = 2 * longint'(s.v) - 65536;
		dkx = 0;
		dky = 0;
		if (a != 0 || b != 0) begin
			first = mag(a) > mag(b);
			rr = first ? a : b;
			t = first ? (b * 65536) / a : (a * 65536) / b;
			theta = (mag(t) * 64'd843314857) >> 16;
			c = longint'(taylor_cos(theta));
			sn = longint'(taylor_sin(theta));
			if (t < 0) sn = -sn;
			rc = scale_trunc(rr, longint'(c), 16);
			rs = scale_trunc(sn, mag(rr), 16);
			if (rr < 0) rs = -rs;
			dkx = first ? rc : rs;
			dky = first ? rs : rc;
		end
		ox = clamp32(scale_trunc(dkx, radius, 30));
		oy = clamp32(scale_trunc(dky, radius, 30));
		fx = clamp32(scale_trunc(longint'(s.px) - off_x, pix_size, 8));
		fy = clamp32(scale_trunc(off_y - longint'(s.py), pix_size, 8));
		vv[0] = fx - ox;
		vv[1] = fy - oy;
		vv[2] = -(focus << 8);
		for (int i = 0; i < 3; i++) m[i] = mag(vv[i]);
		mx = m[0];
		if (m[1] > mx) mx = m[1];
		if (m[2] > mx) mx = m[2];
		if (mx == 0) begin
			dd[0] = 0;
			dd[1] = 0;
			dd[2] = -longint'(Q30);
		end else begin
			sh = 0;
			if (mx >= Q30) begin
				while ((mx >> sh) >= Q30) sh++;
				for (int i = 0; i < 3; i++) m[i] >>= sh;
			end else begin
				while ((mx << sh) < (Q30 >> 1)) sh++;
				for (int i = 0; i < 3; i++) m[i] <<= sh;
			end
			sum = 0;
			for (int i = 0; i < 3; i++) sum += m[i] * m[i];
			len = int_sqrt(sum);
			for (int i = 0; i < 3; i++) begin
				c = longint'((m[i] << 30) / len);
				dd[i] = vv[i] < 0 ? -c : c;
			end
		end
		r.ox = ox[31:0];
		r.oy = oy[31:0];
		r.dx = dd[0][31:0];
		r.dy = dd[1][31:0];
		r.dz = dd[2][31:0];
		return r;
	endfunction

	// input side: accept at the rising edge, next word at the falling edge
	always @(posedge clk) begin
		taken <= in_valid && in_ready;
		if (in_valid && in_ready)
			expected_rays.push_back(trace_ray('{pixel_x, pixel_y, lens_u, lens_v}));
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || taken)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				in_gap = $urandom_range(1, 11) - 1;
				in_valid <= 0;
			end else if (pending_samples.size() > 0) begin
				sample_t s;
				s = pending_samples.pop_front();
				pixel_x <= s.px;
				pixel_y <= s.py;
				lens_u <= s.u;
				lens_v <= s.v;
				in_valid <= 1;
			end else
				in_valid <= 0;
		end
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(1, 11) - 1;
				out_ready <= 0;
			end else
				out_ready <= 1;
		end
	end

	// result checking and watchdog
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			rays_seen++;
			if (expected_rays.size() == 0) begin
				$display("%0t: unexpected ray word ox=%h oy=%h", $time, origin_x, origin_y);
				errors++;
			end else begin
				ray_t e;
				e = expected_rays.pop_front();
				if (origin_x !== e.ox) begin
					$display("%0t: origin_x expected %h got %h", $time, e.ox, origin_x);
					errors++;
				end
				if (origin_y !== e.oy) begin
					$display("%0t: origin_y expected %h got %h", $time, e.oy, origin_y);
					errors++;
				end
				if (dir_x !== e.dx) begin
					$display("%0t: dir_x expected %h got %h", $time, e.dx, dir_x);
					errors++;
				end
				if (dir_y !== e.dy) begin
					$display("%0t: dir_y expected %h got %h", $time, e.dy, dir_y);
					errors++;
				end
				if (dir_z !== e.dz) begin
					$display("%0t: dir_z expected %h got %h", $time, e.dz, dir_z);
					errors++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic apply_setting(longint ox, longint oy, longint ps, longint fd, longint lr);
		@(negedge clk);
		write_reg(tlrg_pkg::CFG_PIXEL_OFFSET_X, ox[31:0]);
		write_reg(tlrg_pkg::CFG_PIXEL_OFFSET_Y, oy[31:0]);
		write_reg(tlrg_pkg::CFG_PIXEL_SIZE, ps[31:0]);
		write_reg(tlrg_pkg::CFG_FOCUS_DEPTH, fd[31:0]);
		write_reg(tlrg_pkg::CFG_LENS_RADIUS, lr[31:0]);
		off_x = ox & 64'hFFFFF;
		off_y = oy & 64'hFFFFF;
		pix_size = ps;
		focus = fd;
		radius = lr;
		phases_run++;
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || in_valid || expected_rays.size() > 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic sample_t random_sample();
		sample_t s;
		s.px = 20'($urandom);
		s.py = 20'($urandom);
		case ($urandom_range(0, 3))
			0: begin
				// near the lens centre
				s.u = 16'(32'd32768 + $urandom_range(0, 64) - 32'd32);
				s.v = 16'(32'd32768 + $urandom_range(0, 64) - 32'd32);
			end
			1: begin
				// on a diagonal, |a| equal to |b|
				s.u = 16'($urandom);
				s.v = $urandom_range(0, 1) ? s.u : 16'd0 - s.u;
			end
			default: begin
				s.u = 16'($urandom);
				s.v = 16'($urandom);
			end
		endcase
		return s;
	endfunction

	initial begin
		sample_t d;
		off_x = 0;
		off_y = 0;
		pix_size = 0;
		focus = longint'(tlrg_pkg::FOCUS_DEPTH_RST);
		radius = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset values: pinhole, zero pixel size
		pending_samples.push_back('{20'd0, 20'd0, 16'd32768, 16'd32768});
		pending_samples.push_back('{20'hFFFFF, 20'hFFFFF, 16'd0, 16'd0});
		drain();

		apply_setting(64'd262144, 64'd131072, 64'h0000_4000, 64'd3 << 16, 64'h0080_0000);
		pending_samples.push_back('{20'd262144, 20'd131072, 16'd32768, 16'd32768});
		pending_samples.push_back('{20'd0, 20'd0, 16'd0, 16'd0});
		pending_samples.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF});
		pending_samples.push_back('{20'd0, 20'hFFFFF, 16'hFFFF, 16'd0});
		pending_samples.push_back('{20'hFFFFF, 20'd0, 16'd0, 16'hFFFF});
		pending_samples.push_back('{20'd1000, 20'd2000, 16'd65000, 16'd32768});
		pending_samples.push_back('{20'd1000, 20'd2000, 16'd32768, 16'd100});
		pending_samples.push_back('{20'd5000, 20'd7000, 16'd40000, 16'd30000});
		pending_samples.push_back('{20'd5000, 20'd7000, 16'd20000, 16'd50000});
		pending_samples.push_back('{20'd5000, 20'd7000, 16'd32769, 16'd32768});
		pending_samples.push_back('{20'd5000, 20'd7000, 16'd32768, 16'd32767});
		pending_samples.push_back('{20'd5000, 20'd7000, 16'd49152, 16'd16384});
		drain();

		// zero focus depth with the pinhole gives the zero vector at the film centre
		apply_setting(64'd1000, 64'd1000, 64'h0100_0000, 64'd0, 64'd0);
		pending_samples.push_back('{20'd1000, 20'd1000, 16'd12345, 16'd54321});
		pending_samples.push_back('{20'd1001, 20'd999, 16'd32768, 16'd32768});
		drain();

		// saturating extremes
		apply_setting(64'd0, 64'hFFFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
		pending_samples.push_back('{20'hFFFFF, 20'd0, 16'd0, 16'd32768});
		pending_samples.push_back('{20'd0, 20'hFFFFF, 16'hFFFF, 16'hFFFF});
		pending_samples.push_back('{20'hFFFFF, 20'hFFFFF, 16'd0, 16'hFFFF});
		drain();

		apply_setting(64'hFFFFF, 64'd0, 64'd1, 64'd1, 64'd1);
		pending_samples.push_back('{20'hFFFFF, 20'd0, 16'd0, 16'd0});
		pending_samples.push_back('{20'd0, 20'hFFFFF, 16'hFFFF, 16'd1});
		drain();

		for (int p = 0; p < 8; p++) begin
			if (p == 7) quiet = 1;
			case (p % 4)
				0: apply_setting(longint'($urandom_range(0, 20'hFFFFF)),
					longint'($urandom_range(0, 20'hFFFFF)), longint'($urandom),
					longint'($urandom_range(1, 32'hFFFF_FFFF)), longint'($urandom));
				1: apply_setting(64'd128 << 8, 64'd96 << 8,
					longint'($urandom_range(0, 32'h0004_0000)),
					longint'($urandom_range(1 << 16, 64 << 16)),
					longint'($urandom_range(0, 32'h0200_0000)));
				2: apply_setting(longint'($urandom_range(0, 20'hFFFFF)),
					longint'($urandom_range(0, 20'hFFFFF)),
					longint'($urandom_range(0, 32'h0000_1000)),
					longint'($urandom_range(1, 255)), longint'($urandom));
				default: apply_setting(64'd512 << 8, 64'd512 << 8, 64'h0000_2000,
					longint'($urandom_range(1, 32'h00FF_FFFF)), 64'd0);
			endcase
			for (int i = 0; i < 48; i++) begin
				d = random_sample();
				pending_samples.push_back(d);
			end
			drain();
		end

		$display("ran %0d register settings, %0d rays checked", phases_run, rays_seen);
		$display("covered pinhole, zero focus, lens centre, diagonals and saturation");
		if (errors == 0 && expected_rays.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/core/tlrg_pkg.sv
rtl/core/thin_lens_ray_generation_unit.sv
tb/testbench.sv
